FILE: design/assert_macros.svh
// Assertion macros shared by the scheduler table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define TTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define TTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/tts_pkg.sv
package tts_pkg;

  // Table geometry.
  localparam int TASK_SLOTS = 8;
  localparam int TIME_BITS  = 16;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  // Fixed field widths of the transactions.
  localparam int CMD_W      = 2;
  localparam int TAG_W      = 16;
  localparam int IN_TIME_W  = 16;
  localparam int FREE_W     = 3;
  localparam int KIND_W     = 3;
  localparam int SLOT_OUT_W = 4;
  localparam int STATUS_W   = 2;
  localparam int PEND_W     = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_DISP = 2'd3
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD  = 3'd0,
    KIND_DEL  = 3'd1,
    KIND_TICK = 3'd2,
    KIND_RUN  = 3'd3,
    KIND_DONE = 3'd4
  } kind_e;

  // Also used for the sticky error code: none, full, empty slot.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DEL,
    ST_TICK,
    ST_TICK_ACK,
    ST_DISP,
    ST_DONE
  } state_e;

  typedef enum logic {
    ALU_TICK,
    ALU_DISP
  } alu_op_e;

  // Payload of one table entry.
  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    logic [TIME_BITS-1:0] delay;
    logic [TIME_BITS-1:0] period;
    logic [PEND_W-1:0]    pending;
  } slot_rec_t;

  // Table write port.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic              used;
    slot_rec_t         rec;
  } tbl_wr_t;

  // Result of the shared slot unit.
  typedef struct packed {
    slot_rec_t rec;
    logic      run;
    logic      keep;
  } alu_res_t;

  // One result transaction.
  typedef struct packed {
    kind_e                 kind;
    logic [SLOT_OUT_W-1:0] slot;
    status_e               status;
    logic [TAG_W-1:0]      run_tag;
    status_e               sticky_error;
    logic                  last;
  } res_t;

endpackage

FILE: design/tts_if.sv
// Command channel.
interface tts_req_if;
  logic                          valid;
  logic                          ready;
  logic [tts_pkg::CMD_W-1:0]     cmd;
  logic [tts_pkg::TAG_W-1:0]     task_tag;
  logic [tts_pkg::IN_TIME_W-1:0] first_delay;
  logic [tts_pkg::IN_TIME_W-1:0] repeat_period;
  logic [tts_pkg::FREE_W-1:0]    slot_to_free;

  modport source (output valid, cmd, task_tag, first_delay, repeat_period, slot_to_free,
                  input ready);
  modport sink (input valid, cmd, task_tag, first_delay, repeat_period, slot_to_free,
                output ready);
endinterface

// Result channel.
interface tts_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [tts_pkg::KIND_W-1:0]     kind;
  logic [tts_pkg::SLOT_OUT_W-1:0] slot;
  logic [tts_pkg::STATUS_W-1:0]   status;
  logic [tts_pkg::TAG_W-1:0]      run_tag;
  logic [tts_pkg::STATUS_W-1:0]   sticky_error;
  logic                           last;

  modport source (output valid, kind, slot, status, run_tag, sticky_error, last,
                  input ready);
  modport sink (input valid, kind, slot, status, run_tag, sticky_error, last,
                output ready);
endinterface

FILE: design/tts_slot_alu.sv
module tts_slot_alu (
  input  tts_pkg::alu_op_e  op_i,
  input  logic              used_i,
  input  tts_pkg::slot_rec_t rec_i,
  output tts_pkg::alu_res_t res_o
);

  logic due;
  logic pend_sat;

  assign due      = (rec_i.delay <= tts_pkg::TIME_BITS'(1));
  assign pend_sat = (rec_i.pending == {tts_pkg::PEND_W{1'b1}});

  // Tick counts the delay down; dispatch consumes one pending run.
  always_comb begin
    res_o      = '0;
    res_o.rec  = rec_i;
    res_o.keep = used_i;
    unique case (op_i)
      tts_pkg::ALU_TICK: begin
        if (due) begin
          res_o.rec.delay = rec_i.period;
          if (!pend_sat) begin
            res_o.rec.pending = rec_i.pending + tts_pkg::PEND_W'(1);
          end
        end else begin
          res_o.rec.delay = rec_i.delay - tts_pkg::TIME_BITS'(1);
        end
      end
      tts_pkg::ALU_DISP: begin
        res_o.run         = used_i && (rec_i.pending != '0);
        res_o.rec.pending = rec_i.pending - tts_pkg::PEND_W'(1);
        res_o.keep        = (rec_i.period != '0);
      end
      default: begin
        res_o.rec = rec_i;
      end
    endcase
  end

endmodule

FILE: design/tts_slot_table.sv
`include "assert_macros.svh"

module tts_slot_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tts_pkg::SLOT_W-1:0]  rd_addr_i,
  output logic                        rd_used_o,
  output tts_pkg::slot_rec_t          rd_rec_o,
  input  tts_pkg::tbl_wr_t            wr_i
);

  logic [tts_pkg::TASK_SLOTS-1:0] used_q;
  tts_pkg::slot_rec_t             rec_q [tts_pkg::TASK_SLOTS];

  // Occupancy bits are cleared by reset; an empty entry's payload never reaches a result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (wr_i.en) begin
      used_q[wr_i.addr] <= wr_i.used;
    end
  end

  // Entry payload.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      rec_q[wr_i.addr] <= wr_i.rec;
    end
  end

  assign rd_used_o = used_q[rd_addr_i];
  assign rd_rec_o  = rec_q[rd_addr_i];

  `TTS_ASSERT(a_used_written, wr_i.en |=> (used_q[$past(wr_i.addr)] == $past(wr_i.used)), "slot occupancy not updated by write")

endmodule

FILE: design/tick_task_scheduler_table_unit.sv
// Task scheduler table with eight slots. Commands arrive on req_i and each produces
// one or more result transactions on rsp_o, the final one marked by last. The block
// takes one command at a time: a sequencer walks the slot table one entry per cycle,
// while rsp_o is not stalled, through a single shared slot unit. Delete visits one
// slot, add walks up to the first free slot (or all eight on a full table), and tick
// and dispatch walk all eight slots and then give a final result; a stalled rsp_o
// holds the sequencer while a result is waiting. A finished result sits in an output
// register, so the next command is accepted as soon as the sequencer is idle.
`include "assert_macros.svh"

module tick_task_scheduler_table_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  tts_req_if.sink   req_i,
  tts_rsp_if.source rsp_o
);

  // Latched command.
  typedef struct packed {
    tts_pkg::cmd_e                     cmd;
    logic [tts_pkg::TAG_W-1:0]         tag;
    logic [tts_pkg::IN_TIME_W-1:0]     delay;
    logic [tts_pkg::IN_TIME_W-1:0]     period;
    logic [tts_pkg::FREE_W-1:0]        free_slot;
  } req_t;

  tts_pkg::state_e            state_q, state_d;
  logic [tts_pkg::SLOT_W-1:0] idx_q, idx_d;
  req_t                       req_q;
  tts_pkg::res_t              out_q, res_d;
  logic                       out_valid_q;
  tts_pkg::status_e           err_q, err_d;

  logic                       req_fire;
  logic                       out_free;
  logic                       emit;
  logic                       idx_last;
  logic                       del_in_range;
  logic [tts_pkg::SLOT_W-1:0] rd_addr;
  logic                       rd_used;
  tts_pkg::slot_rec_t         rd_rec;
  tts_pkg::tbl_wr_t           wr;
  tts_pkg::alu_op_e           alu_op;
  tts_pkg::alu_res_t          alu_res;

  assign req_i.ready  = (state_q == tts_pkg::ST_IDLE);
  assign req_fire     = req_i.valid && req_i.ready;
  assign out_free     = !out_valid_q || rsp_o.ready;
  assign idx_last     = (idx_q == tts_pkg::SLOT_W'(tts_pkg::TASK_SLOTS - 1));
  assign del_in_range = (32'(req_q.free_slot) < 32'(tts_pkg::TASK_SLOTS));

  tts_slot_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_used_o (rd_used),
    .rd_rec_o  (rd_rec),
    .wr_i      (wr)
  );

  tts_slot_alu u_alu (
    .op_i   (alu_op),
    .used_i (rd_used),
    .rec_i  (rd_rec),
    .res_o  (alu_res)
  );

  // Sequencer: next state, table writes and result formation.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    rd_addr = idx_q;
    alu_op  = tts_pkg::ALU_TICK;
    wr      = '0;
    emit    = 1'b0;
    res_d   = '0;
    err_d   = err_q;
    unique case (state_q)
      tts_pkg::ST_IDLE: begin
        idx_d = '0;
        if (req_fire) begin
          unique case (tts_pkg::cmd_e'(req_i.cmd))
            tts_pkg::CMD_ADD:  state_d = tts_pkg::ST_ADD;
            tts_pkg::CMD_DEL:  state_d = tts_pkg::ST_DEL;
            tts_pkg::CMD_TICK: state_d = tts_pkg::ST_TICK;
            tts_pkg::CMD_DISP: state_d = tts_pkg::ST_DISP;
            default:           state_d = tts_pkg::ST_IDLE;
          endcase
        end
      end
      // Search for the lowest free slot.
      tts_pkg::ST_ADD: begin
        res_d.kind = tts_pkg::KIND_ADD;
        res_d.last = 1'b1;
        if (!rd_used) begin
          if (out_free) begin
            wr.en              = 1'b1;
            wr.addr            = idx_q;
            wr.used            = 1'b1;
            wr.rec.tag         = req_q.tag;
            wr.rec.delay       = tts_pkg::TIME_BITS'(req_q.delay);
            wr.rec.period      = tts_pkg::TIME_BITS'(req_q.period);
            wr.rec.pending     = '0;
            emit               = 1'b1;
            res_d.slot         = tts_pkg::SLOT_OUT_W'(idx_q);
            res_d.status       = tts_pkg::STAT_OK;
            state_d            = tts_pkg::ST_IDLE;
          end
        end else if (idx_last) begin
          if (out_free) begin
            emit         = 1'b1;
            err_d        = tts_pkg::STAT_FULL;
            res_d.slot   = tts_pkg::SLOT_OUT_W'(tts_pkg::TASK_SLOTS);
            res_d.status = tts_pkg::STAT_FULL;
            state_d      = tts_pkg::ST_IDLE;
          end
        end else begin
          idx_d = idx_q + tts_pkg::SLOT_W'(1);
        end
      end
      // Free one slot; an empty or out-of-range slot is flagged.
      tts_pkg::ST_DEL: begin
        rd_addr    = tts_pkg::SLOT_W'(req_q.free_slot);
        res_d.kind = tts_pkg::KIND_DEL;
        res_d.slot = tts_pkg::SLOT_OUT_W'(req_q.free_slot);
        res_d.last = 1'b1;
        if (out_free) begin
          emit    = 1'b1;
          wr.en   = del_in_range;
          wr.addr = rd_addr;
          wr.used = 1'b0;
          wr.rec  = rd_rec;
          if (!(del_in_range && rd_used)) begin
            err_d        = tts_pkg::STAT_EMPTY;
            res_d.status = tts_pkg::STAT_EMPTY;
          end
          state_d = tts_pkg::ST_IDLE;
        end
      end
      // Count down every live slot, one per cycle.
      tts_pkg::ST_TICK: begin
        alu_op  = tts_pkg::ALU_TICK;
        wr.en   = rd_used;
        wr.addr = idx_q;
        wr.used = 1'b1;
        wr.rec  = alu_res.rec;
        if (idx_last) begin
          state_d = tts_pkg::ST_TICK_ACK;
        end else begin
          idx_d = idx_q + tts_pkg::SLOT_W'(1);
        end
      end
      tts_pkg::ST_TICK_ACK: begin
        res_d.kind = tts_pkg::KIND_TICK;
        res_d.last = 1'b1;
        if (out_free) begin
          emit    = 1'b1;
          state_d = tts_pkg::ST_IDLE;
        end
      end
      // Report each slot with pending runs; hold while the output is busy.
      tts_pkg::ST_DISP: begin
        alu_op        = tts_pkg::ALU_DISP;
        res_d.kind    = tts_pkg::KIND_RUN;
        res_d.slot    = tts_pkg::SLOT_OUT_W'(idx_q);
        res_d.run_tag = rd_rec.tag;
        if (!alu_res.run || out_free) begin
          if (alu_res.run) begin
            emit    = 1'b1;
            wr.en   = 1'b1;
            wr.addr = idx_q;
            wr.used = alu_res.keep;
            wr.rec  = alu_res.rec;
          end
          if (idx_last) begin
            state_d = tts_pkg::ST_DONE;
          end else begin
            idx_d = idx_q + tts_pkg::SLOT_W'(1);
          end
        end
      end
      tts_pkg::ST_DONE: begin
        res_d.kind = tts_pkg::KIND_DONE;
        res_d.last = 1'b1;
        if (out_free) begin
          emit    = 1'b1;
          state_d = tts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tts_pkg::ST_IDLE;
      end
    endcase
    res_d.sticky_error = err_d;
  end

  // Sequencer state, error latch and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tts_pkg::ST_IDLE;
      idx_q       <= '0;
      err_q       <= tts_pkg::STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (emit) begin
        err_q       <= err_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Command and result payload.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q.cmd       <= tts_pkg::cmd_e'(req_i.cmd);
      req_q.tag       <= req_i.task_tag;
      req_q.delay     <= req_i.first_delay;
      req_q.period    <= req_i.repeat_period;
      req_q.free_slot <= req_i.slot_to_free;
    end
    if (emit) begin
      out_q <= res_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.kind         = out_q.kind;
  assign rsp_o.slot         = out_q.slot;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.run_tag      = out_q.run_tag;
  assign rsp_o.sticky_error = out_q.sticky_error;
  assign rsp_o.last         = out_q.last;

  `TTS_ASSERT(a_busy_after_accept, req_fire |=> (state_q != tts_pkg::ST_IDLE), "sequencer idle after accepting a command")
  `TTS_ASSERT(a_write_only_busy, wr.en |-> (state_q != tts_pkg::ST_IDLE), "table written while idle")
  `TTS_ASSERT(a_run_not_last, (out_valid_q && (out_q.kind == tts_pkg::KIND_RUN)) |-> !out_q.last, "run result marked last")
  `TTS_ASSERT(a_full_slot, (out_valid_q && (out_q.status == tts_pkg::STAT_FULL)) |-> (out_q.slot == tts_pkg::SLOT_OUT_W'(tts_pkg::TASK_SLOTS)), "full status without full slot code")
  `TTS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_q, "result valid during reset")

endmodule
